### rtl/mvrm_pkg.sv
// shared types and constants of the multi-voice resampling mixer
`default_nettype none

package mvrm_pkg;

    localparam int VOICES_DEF       = 8;
    localparam int STORE_FRAMES_DEF = 16384;

    localparam int SAT_MAX = 32767;
    localparam int SAT_MIN = -32768;

    typedef enum logic [1:0] {
        FN_LOAD  = 2'd0,
        FN_START = 2'd1,
        FN_MIX   = 2'd2,
        FN_NONE  = 2'd3
    } func_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_START,
        ST_SRD,
        ST_SCMP,
        ST_SDEC,
        ST_PLACE,
        ST_MRD,
        ST_MCHK,
        ST_MRA,
        ST_MRB,
        ST_MP1,
        ST_MP2,
        ST_MP3,
        ST_MP4,
        ST_MP5,
        ST_MP6,
        ST_MEND,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [13:0] base;
        logic [14:0] length;
        logic        mono;
        logic [31:0] position;
        logic [19:0] step;
        logic [15:0] gain;
    } voice_rec_t;

endpackage

`default_nettype wire

### rtl/multi_voice_resampling_mixer_core.sv
// multi-voice resampling mixer: clip store, voice records and mix sequencer
`default_nettype none

// Sample-playback mixer. Clip frames live in a synchronous store with one write and one
// read port, and each voice's record (base, length, position, step, gain) in a small
// synchronous memory; a sequencer works on one item at a time. A start places a voice
// in an idle slot or, when every voice is busy, first scans the gains one record per
// read. A mix reads each voice record in turn: an active voice takes two store reads,
// is interpolated and scaled by its gain through partial products for each channel
// (once for a mono voice), and the sums are then saturated.
// STORE_FRAMES must be a power of two; store addresses wrap at that size.
module multi_voice_resampling_mixer_core #(
    parameter int VOICES       = mvrm_pkg::VOICES_DEF,
    parameter int STORE_FRAMES = mvrm_pkg::STORE_FRAMES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // load_addr, load_left, load_right, clip_base, clip_length, is_mono, step_q16,
    // volume_q15
    input  logic [111:0] s_tdata,
    // func
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // play_taken, play_voice, left_out, right_out, active_mask, zero pad
    output logic [47:0]  m_tdata
);
    import mvrm_pkg::*;

    localparam int VW     = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int ADDR_W = $clog2(STORE_FRAMES);
    localparam int SUM_W  = ((ADDR_W > 17) ? ADDR_W : 17) + 1;
    localparam int ACC_W  = 22 + VW;

    // memories
    logic [31:0]  store_mem [STORE_FRAMES];
    voice_rec_t   vmem [VOICES];

    logic              st_we;
    logic [ADDR_W-1:0] st_waddr;
    logic [31:0]       st_wdata;
    logic [ADDR_W-1:0] st_raddr;
    logic [31:0]       sq_reg;

    logic              vm_we;
    logic [VW-1:0]     vm_waddr;
    voice_rec_t        vm_wdata;
    logic              vm_rd;
    logic [VW-1:0]     vm_raddr;
    voice_rec_t        vq_reg;

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[st_waddr] <= st_wdata;
        end
        sq_reg <= store_mem[st_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (vm_we)
        begin
            vmem[vm_waddr] <= vm_wdata;
        end
        if (vm_rd)
        begin
            vq_reg <= vmem[vm_raddr];
        end
    end

    // control registers
    state_t            state_reg, state_next;
    logic [VOICES-1:0] act_reg, act_next;
    logic              mval_reg, mval_next;

    // data registers
    logic [47:0]       mdata_reg, mdata_next;
    logic [13:0]       base_reg, base_next;
    logic [14:0]       len_reg, len_next;
    logic              mono_reg, mono_next;
    logic [19:0]       step_reg, step_next;
    logic [15:0]       vol_reg, vol_next;
    logic [VW-1:0]     vidx_reg, vidx_next;
    logic [VW-1:0]     best_reg, best_next;
    logic [15:0]       bestg_reg, bestg_next;
    logic [VW-1:0]     slot_reg, slot_next;
    logic              ch_reg, ch_next;
    logic [ADDR_W-1:0] addrb_reg, addrb_next;
    logic [15:0]       frac_reg, frac_next;
    logic [31:0]       fa_reg, fa_next;
    logic [31:0]       fb_reg, fb_next;
    logic signed [33:0] prod1_reg, prod1_next;
    logic signed [34:0] v_reg, v_next;
    logic [32:0]        pl_reg, pl_next;
    logic signed [34:0] ph_reg, ph_next;
    logic signed [51:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0] accl_reg, accl_next;
    logic signed [ACC_W-1:0] accr_reg, accr_next;
    logic               rtaken_reg, rtaken_next;
    logic [2:0]         rvoice_reg, rvoice_next;
    logic [15:0]        rleft_reg, rleft_next;
    logic [15:0]        rright_reg, rright_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            act_reg   <= '0;
            mval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            act_reg   <= act_next;
            mval_reg  <= mval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mdata_reg  <= mdata_next;
        base_reg   <= base_next;
        len_reg    <= len_next;
        mono_reg   <= mono_next;
        step_reg   <= step_next;
        vol_reg    <= vol_next;
        vidx_reg   <= vidx_next;
        best_reg   <= best_next;
        bestg_reg  <= bestg_next;
        slot_reg   <= slot_next;
        ch_reg     <= ch_next;
        addrb_reg  <= addrb_next;
        frac_reg   <= frac_next;
        fa_reg     <= fa_next;
        fb_reg     <= fb_next;
        prod1_reg  <= prod1_next;
        v_reg      <= v_next;
        pl_reg     <= pl_next;
        ph_reg     <= ph_next;
        prod_reg   <= prod_next;
        accl_reg   <= accl_next;
        accr_reg   <= accr_next;
        rtaken_reg <= rtaken_next;
        rvoice_reg <= rvoice_next;
        rleft_reg  <= rleft_next;
        rright_reg <= rright_next;
    end

    // first idle voice
    logic          idle_found;
    logic [VW-1:0] idle_idx;

    always_comb
    begin
        idle_found = 1'b0;
        idle_idx   = '0;
        for (int k = VOICES - 1; k >= 0; k--)
        begin
            if (!act_reg[k])
            begin
                idle_found = 1'b1;
                idle_idx   = VW'(k);
            end
        end
    end

    // datapath helpers
    logic [15:0]        pos_hi;
    logic [16:0]        i_plus;
    logic [15:0]        j_idx;
    logic [SUM_W-1:0]   sum_a, sum_b, sum_ld;
    logic signed [15:0] smp_a, smp_b;
    logic signed [16:0] diff;
    logic signed [51:0] biased;
    logic signed [20:0] contrib;
    logic signed [ACC_W-1:0] contrib_ext;
    logic [7:0]         slot_ext;
    logic [31:0]        mask_ext;
    logic               last_voice;

    always_comb
    begin
        pos_hi = vq_reg.position[31:16];
        i_plus = {1'b0, pos_hi} + 17'd1;
        j_idx  = (i_plus < {2'b0, vq_reg.length}) ? i_plus[15:0] : pos_hi;
        sum_a  = SUM_W'(vq_reg.base) + SUM_W'(pos_hi);
        sum_b  = SUM_W'(vq_reg.base) + SUM_W'(j_idx);
        sum_ld = SUM_W'(s_tdata[13:0]);
        smp_a  = ch_reg ? $signed(fa_reg[31:16]) : $signed(fa_reg[15:0]);
        smp_b  = ch_reg ? $signed(fb_reg[31:16]) : $signed(fb_reg[15:0]);
        diff   = {smp_b[15], smp_b} - {smp_a[15], smp_a};
        // division by 2^31 truncating toward zero
        biased  = prod_reg + (prod_reg[51] ? 52'sd2147483647 : 52'sd0);
        contrib = biased[51:31];
        contrib_ext = {{(ACC_W - 21){contrib[20]}}, contrib};
        slot_ext   = 8'(slot_reg);
        mask_ext   = 32'(act_reg);
        last_voice = (vidx_reg == VW'(VOICES - 1));
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;

    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        mval_next   = mval_reg;
        mdata_next  = mdata_reg;
        base_next   = base_reg;
        len_next    = len_reg;
        mono_next   = mono_reg;
        step_next   = step_reg;
        vol_next    = vol_reg;
        vidx_next   = vidx_reg;
        best_next   = best_reg;
        bestg_next  = bestg_reg;
        slot_next   = slot_reg;
        ch_next     = ch_reg;
        addrb_next  = addrb_reg;
        frac_next   = frac_reg;
        fa_next     = fa_reg;
        fb_next     = fb_reg;
        prod1_next  = prod1_reg;
        v_next      = v_reg;
        pl_next     = pl_reg;
        ph_next     = ph_reg;
        prod_next   = prod_reg;
        accl_next   = accl_reg;
        accr_next   = accr_reg;
        rtaken_next = rtaken_reg;
        rvoice_next = rvoice_reg;
        rleft_next  = rleft_reg;
        rright_next = rright_reg;

        st_we    = 1'b0;
        st_waddr = sum_ld[ADDR_W-1:0];
        st_wdata = s_tdata[45:14];
        st_raddr = addrb_reg;
        vm_we    = 1'b0;
        vm_waddr = slot_reg;
        vm_wdata = vq_reg;
        vm_rd    = 1'b0;
        vm_raddr = vidx_reg;

        if (mval_reg && m_tready)
        begin
            mval_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    base_next   = s_tdata[59:46];
                    len_next    = s_tdata[74:60];
                    mono_next   = s_tdata[75];
                    step_next   = s_tdata[95:76];
                    vol_next    = s_tdata[111:96];
                    rtaken_next = 1'b0;
                    rvoice_next = '0;
                    rleft_next  = '0;
                    rright_next = '0;
                    vidx_next   = '0;
                    accl_next   = '0;
                    accr_next   = '0;
                    unique case (func_t'(s_tuser))
                        FN_LOAD:
                        begin
                            st_we      = 1'b1;
                            state_next = ST_DONE;
                        end
                        FN_START: state_next = ST_START;
                        FN_MIX:   state_next = ST_MRD;
                        FN_NONE:  state_next = ST_DONE;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_START:
            begin
                if (len_reg == '0 || vol_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else if (idle_found)
                begin
                    slot_next  = idle_idx;
                    state_next = ST_PLACE;
                end
                else
                begin
                    state_next = ST_SRD;
                end
            end
            ST_SRD:
            begin
                vm_rd      = 1'b1;
                state_next = ST_SCMP;
            end
            ST_SCMP:
            begin
                // quietest busy voice, earliest on a tie
                if (vidx_reg == '0 || vq_reg.gain < bestg_reg)
                begin
                    best_next  = vidx_reg;
                    bestg_next = vq_reg.gain;
                end
                if (last_voice)
                begin
                    state_next = ST_SDEC;
                end
                else
                begin
                    vidx_next  = vidx_reg + 1'b1;
                    state_next = ST_SRD;
                end
            end
            ST_SDEC:
            begin
                if (bestg_reg > vol_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    slot_next  = best_reg;
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                vm_we             = 1'b1;
                vm_wdata.base     = base_reg;
                vm_wdata.length   = len_reg;
                vm_wdata.mono     = mono_reg;
                vm_wdata.position = '0;
                vm_wdata.step     = (step_reg == '0) ? 20'h10000 : step_reg;
                vm_wdata.gain     = (vol_reg > 16'd32768) ? 16'd32768 : vol_reg;
                act_next[slot_reg] = 1'b1;
                rtaken_next = 1'b1;
                rvoice_next = slot_ext[2:0];
                state_next  = ST_DONE;
            end
            ST_MRD:
            begin
                vm_rd      = 1'b1;
                state_next = ST_MCHK;
            end
            ST_MCHK:
            begin
                if (!act_reg[vidx_reg] || pos_hi >= {1'b0, vq_reg.length})
                begin
                    act_next[vidx_reg] = 1'b0;
                    if (last_voice)
                    begin
                        state_next = ST_MEND;
                    end
                    else
                    begin
                        vidx_next  = vidx_reg + 1'b1;
                        state_next = ST_MRD;
                    end
                end
                else
                begin
                    st_raddr   = sum_a[ADDR_W-1:0];
                    addrb_next = sum_b[ADDR_W-1:0];
                    frac_next  = vq_reg.position[15:0];
                    state_next = ST_MRA;
                end
            end
            ST_MRA:
            begin
                fa_next    = sq_reg;
                state_next = ST_MRB;
            end
            ST_MRB:
            begin
                fb_next    = sq_reg;
                ch_next    = 1'b0;
                state_next = ST_MP1;
            end
            ST_MP1:
            begin
                prod1_next = diff * $signed({1'b0, frac_reg});
                state_next = ST_MP2;
            end
            ST_MP2:
            begin
                v_next = $signed({{3{smp_a[15]}}, smp_a, 16'h0000})
                       + $signed({prod1_reg[33], prod1_reg});
                state_next = ST_MP3;
            end
            ST_MP3:
            begin
                pl_next    = 33'(v_reg[16:0]) * 33'(vq_reg.gain);
                state_next = ST_MP4;
            end
            ST_MP4:
            begin
                ph_next    = $signed(v_reg[34:17]) * $signed({1'b0, vq_reg.gain});
                state_next = ST_MP5;
            end
            ST_MP5:
            begin
                prod_next  = $signed({ph_reg, 17'h00000}) + $signed({19'h00000, pl_reg});
                state_next = ST_MP6;
            end
            ST_MP6:
            begin
                if (vq_reg.mono)
                begin
                    accl_next = accl_reg + contrib_ext;
                    accr_next = accr_reg + contrib_ext;
                end
                else if (!ch_reg)
                begin
                    accl_next = accl_reg + contrib_ext;
                end
                else
                begin
                    accr_next = accr_reg + contrib_ext;
                end
                if (!vq_reg.mono && !ch_reg)
                begin
                    ch_next    = 1'b1;
                    state_next = ST_MP1;
                end
                else
                begin
                    vm_we             = 1'b1;
                    vm_waddr          = vidx_reg;
                    vm_wdata.position = vq_reg.position + 32'(vq_reg.step);
                    if (last_voice)
                    begin
                        state_next = ST_MEND;
                    end
                    else
                    begin
                        vidx_next  = vidx_reg + 1'b1;
                        state_next = ST_MRD;
                    end
                end
            end
            ST_MEND:
            begin
                priority if (accl_reg > SAT_MAX) rleft_next = 16'h7FFF;
                else if (accl_reg < SAT_MIN)     rleft_next = 16'h8000;
                else                             rleft_next = accl_reg[15:0];
                priority if (accr_reg > SAT_MAX) rright_next = 16'h7FFF;
                else if (accr_reg < SAT_MIN)     rright_next = 16'h8000;
                else                             rright_next = accr_reg[15:0];
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!mval_reg || m_tready)
                begin
                    mval_next  = 1'b1;
                    mdata_next = {4'h0, mask_ext[7:0], rright_reg, rleft_reg,
                                  rvoice_reg, rtaken_reg};
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // a placed voice is active right after
    a_place_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PLACE) |=> act_reg[$past(slot_reg)])
        else $error("placed voice not marked active");

    // a taken start word never carries mix samples
    a_taken_no_mix: assert property (@(posedge clk) disable iff (!rst_n)
        (mval_reg && mdata_reg[0]) |-> (mdata_reg[35:4] == '0))
        else $error("start result carries samples");

    // clip store is written only while taking a load word
    a_store_we: assert property (@(posedge clk) disable iff (!rst_n)
        st_we |-> (s_tvalid && s_tready && s_tuser == FN_LOAD))
        else $error("stray clip store write");

endmodule

`default_nettype wire
